### rtl/core/dog_scale_space_extrema_detect_macros.svh
// Assertion macros used by the extrema detector checker
`ifndef DOG_SCALE_SPACE_EXTREMA_DETECT_MACROS_SVH
`define DOG_SCALE_SPACE_EXTREMA_DETECT_MACROS_SVH

// clocked check, masked while reset is asserted
`define DSED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define DSED_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/dsed_pkg.sv
// Package: constants, register codes and shared types of the DoG extrema detector
package dsed_pkg;

  localparam int MaxCols  = 1024;
  localparam int ColW     = $clog2(MaxCols);
  localparam int RowLimit = 4096;
  localparam int RowW     = $clog2(RowLimit);
  localparam int Border   = 5;
  localparam int PixW     = 16;
  localparam int Layers   = 3;
  localparam int ThrW     = 15;
  localparam int ColRegW  = 11;
  localparam int RowRegW  = 13;
  localparam int CfgW     = 15;
  localparam int LineW    = Layers * PixW;
  localparam int InDataW  = 48;
  localparam int OutDataW = 48;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_COLUMNS   = 2'd1,
    CFG_ROWS      = 2'd2
  } cfg_idx_t;

  typedef logic signed [PixW-1:0] pix_t;

  typedef struct packed {
    logic            dv;
    logic            interior;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } meta_t;

  typedef struct packed {
    logic ge;
    logic le;
  } cmp_t;

  typedef struct packed {
    logic signed [PixW-1:0] value;
    logic [ColW-1:0]        col;
    logic [RowW-1:0]        row;
    logic                   is_min;
    logic                   is_max;
    logic                   dv;
  } result_t;

endpackage

### rtl/core/dsed_ram.sv
// Generic simple dual-port RAM with registered read, read-before-write
module dsed_ram #(
  parameter int Width = 48,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/dsed_lane.sv
// One layer lane: compares the centre pixel against the nine pixels of a 3x3 window
module dsed_lane
  import dsed_pkg::*;
(
  input  pix_t            centre,
  input  logic [8:0][PixW-1:0] nbr,
  output cmp_t            res
);

  logic [8:0] ge_v;
  logic [8:0] le_v;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      ge_v[k] = !(centre < signed'(nbr[k]));
      le_v[k] = !(centre > signed'(nbr[k]));
    end
    res.ge = &ge_v;
    res.le = &le_v;
  end

endmodule

### rtl/core/dsed_merge.sv
// Merge: combines lane compares, border and contrast tests into one result
module dsed_merge
  import dsed_pkg::*;
(
  input  meta_t             meta,
  input  pix_t              value,
  input  logic              above,
  input  cmp_t [Layers-1:0] cmp,
  output result_t           res
);

  logic all_ge;
  logic all_le;
  logic judge;

  always_comb begin
    all_ge = 1'b1;
    all_le = 1'b1;
    for (int l = 0; l < Layers; l++) begin
      all_ge &= cmp[l].ge;
      all_le &= cmp[l].le;
    end
    judge = meta.dv & meta.interior & above;
    res        = '0;
    if (meta.dv) begin
      res.dv     = 1'b1;
      res.is_max = judge & (value > 0) & all_ge;
      res.is_min = judge & (value < 0) & all_le;
      res.row    = meta.row;
      res.col    = meta.col;
      res.value  = value;
    end
  end

endmodule

### rtl/core/dog_scale_space_extrema_detect.sv
// Top level: DoG 3x3x3 scale-space extrema detector
// Takes one pixel triple (layer below, centre layer, layer above) per clock in raster
// order while in_tready is high, and returns one result per transfer, judging the pixel
// one row and one column behind. The result is registered through four register stages:
// line store read, window shift, three parallel layer lanes, merge into the output
// register. The line store is two 1024 x 48 RAM banks read at the current column on
// every input transfer; after reset both banks are cleared in a single pass, during
// which in_tready stays low while configuration writes are still taken. Change image
// size or threshold only between transfers with no result pending.
module dog_scale_space_extrema_detect
  import dsed_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // lower_level, centre_level, upper_level
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // decision_valid, is_maximum, is_minimum,
                                          // centre_row, centre_column, centre_value, pad
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CfgW-1:0]     cfg_wdata
);

  // config registers
  logic [ThrW-1:0]    thr_r;
  logic [ColRegW-1:0] cols_r;
  logic [RowRegW-1:0] rows_r;
  logic [ColRegW-1:0] cols_eff;
  logic [RowRegW-1:0] rows_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= '0;
      cols_r <= ColRegW'(MaxCols);
      rows_r <= RowRegW'(1024);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: thr_r  <= cfg_wdata[ThrW-1:0];
        CFG_COLUMNS:   cols_r <= cfg_wdata[ColRegW-1:0];
        CFG_ROWS:      rows_r <= cfg_wdata[RowRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cols_eff = cols_r;
    if (cols_r == '0) cols_eff = ColRegW'(1);
    else if (cols_r > ColRegW'(MaxCols)) cols_eff = ColRegW'(MaxCols);
    rows_eff = rows_r;
    if (rows_r == '0) rows_eff = RowRegW'(1);
    else if (rows_r > RowRegW'(RowLimit)) rows_eff = RowRegW'(RowLimit);
  end

  // pipeline handshake
  logic v1_r, v2_r, v3_r, vo_r;
  logic rdy_o, rdy3, rdy2, rdy1;
  logic acc;
  logic clr_r, clr_nxt;
  logic [ColW-1:0] clr_addr_r;

  assign rdy_o     = !vo_r || out_tready;
  assign rdy3      = !v3_r || rdy_o;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1 && !clr_r;
  assign acc       = in_tvalid && in_tready;

  // line store clearing pass
  assign clr_nxt = clr_r && !(&clr_addr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // position counters
  logic [ColW-1:0] col_r, col_nxt;
  logic [RowW-1:0] row_r, row_nxt;
  logic [ColRegW-1:0] c_inc;
  logic [RowRegW-1:0] r_inc;

  always_comb begin
    c_inc   = {1'b0, col_r} + ColRegW'(1);
    r_inc   = {1'b0, row_r} + RowRegW'(1);
    col_nxt = c_inc[ColW-1:0];
    row_nxt = row_r;
    if (c_inc >= cols_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= rows_eff) ? '0 : r_inc[RowW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store banks: bank (row & 1) holds row-2, the other holds row-1
  logic [1:0][LineW-1:0] bank_rd;
  logic [ColW-1:0]       ram_waddr;
  logic [LineW-1:0]      ram_wdata;

  assign ram_waddr = clr_r ? clr_addr_r : col_r;
  assign ram_wdata = clr_r ? '0 : in_tdata[LineW-1:0];

  for (genvar b = 0; b < 2; b++) begin : g_bank
    dsed_ram #(.Width(LineW), .Depth(MaxCols)) u_ram (
      .clk   (clk),
      .we    (clr_r || (acc && (row_r[0] == 1'(b)))),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (acc),
      .raddr (col_r),
      .rdata (bank_rd[b])
    );
  end

  // stage 1: line store data available
  logic [LineW-1:0] now1_r;
  logic [RowW-1:0]  row1_r;
  logic [ColW-1:0]  col1_r;
  logic [LineW-1:0] older1;
  logic [LineW-1:0] mid1;
  meta_t            meta1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      now1_r <= in_tdata[LineW-1:0];
      row1_r <= row_r;
      col1_r <= col_r;
    end
  end

  always_comb begin
    older1         = bank_rd[row1_r[0]];
    mid1           = bank_rd[!row1_r[0]];
    meta1.dv       = (row1_r >= RowW'(2)) && (col1_r >= ColW'(2));
    meta1.row      = meta1.dv ? row1_r - RowW'(1) : '0;
    meta1.col      = meta1.dv ? col1_r - ColW'(1) : '0;
    meta1.interior = (meta1.row >= RowW'(Border))
                  && (({1'b0, meta1.row} + RowRegW'(Border)) < rows_eff)
                  && (meta1.col >= ColW'(Border))
                  && (({1'b0, meta1.col} + ColRegW'(Border)) < cols_eff);
  end

  // stage 2: 3x3x3 window, [layer][row][column], column 2 newest
  logic [PixW-1:0] win_r [Layers][3][3];
  meta_t           meta2_r;
  logic            ld2;

  assign ld2 = v1_r && rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      for (int l = 0; l < Layers; l++) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            win_r[l][i][j] <= '0;
          end
        end
      end
    end else begin
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (ld2) begin
        for (int l = 0; l < Layers; l++) begin
          for (int i = 0; i < 3; i++) begin
            win_r[l][i][0] <= win_r[l][i][1];
            win_r[l][i][1] <= win_r[l][i][2];
          end
          win_r[l][0][2] <= older1[l*PixW +: PixW];
          win_r[l][1][2] <= mid1[l*PixW +: PixW];
          win_r[l][2][2] <= now1_r[l*PixW +: PixW];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      meta2_r <= meta1;
    end
  end

  // lanes, one per layer
  pix_t                    centre2;
  logic [16:0]             cx2;
  logic [16:0]             mag2;
  logic                    above2;
  cmp_t [Layers-1:0]       cmp2;
  logic [Layers-1:0][8:0][PixW-1:0] nbr2;

  assign centre2 = pix_t'(win_r[1][1][1]);

  always_comb begin
    cx2    = {centre2[PixW-1], centre2};
    mag2   = cx2[16] ? (~cx2 + 17'd1) : cx2;
    above2 = mag2 > {2'b00, thr_r};
    for (int l = 0; l < Layers; l++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          nbr2[l][i*3 + j] = win_r[l][i][j];
        end
      end
    end
  end

  for (genvar l = 0; l < Layers; l++) begin : g_lane
    dsed_lane u_lane (
      .centre (centre2),
      .nbr    (nbr2[l]),
      .res    (cmp2[l])
    );
  end

  // stage 3: lane results
  cmp_t [Layers-1:0] cmp3_r;
  meta_t             meta3_r;
  pix_t              val3_r;
  logic              above3_r;
  result_t           res3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      cmp3_r   <= cmp2;
      meta3_r  <= meta2_r;
      val3_r   <= centre2;
      above3_r <= above2;
    end
  end

  dsed_merge u_merge (
    .meta  (meta3_r),
    .value (val3_r),
    .above (above3_r),
    .cmp   (cmp3_r),
    .res   (res3)
  );

  // output register
  result_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (rdy_o) begin
      vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && rdy_o) begin
      out_r <= res3;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {(OutDataW - $bits(result_t))'(0), out_r};

endmodule

### rtl/core/dsed_checker.sv
// Port-level checker for the DoG extrema detector, bound to the top level
`include "dog_scale_space_extrema_detect_macros.svh"

module dsed_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  `DSED_ASSERT(a_out_hold,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata),
    "result changed while stalled")
  `DSED_ASSERT_RST(a_rst_quiet,
    !rst_n |=> !in_tready && !out_tvalid,
    "ports active right after reset")
  `DSED_ASSERT(a_flag_needs_valid,
    out_tvalid && (out_tdata[1] || out_tdata[2]) |->
      out_tdata[0] && !(out_tdata[1] && out_tdata[2]),
    "extremum flags inconsistent")
  `DSED_ASSERT(a_invalid_zero,
    out_tvalid && !out_tdata[0] |-> out_tdata[47:1] == 47'd0,
    "non-judged result carries data")
  `DSED_ASSERT(a_judged_pos,
    out_tvalid && out_tdata[0] |-> out_tdata[14:3] != 12'd0 && out_tdata[24:15] != 10'd0,
    "judged centre on first row or column")

endmodule

bind dog_scale_space_extrema_detect dsed_checker u_dsed_checker (.*);
